// ===== hw/rtl/size_class_chunk_allocator_macros.svh =====
// Assertion macros for the size class chunk allocator.
// Users must have clk and rst in scope; no other dependencies.
`ifndef SIZE_CLASS_CHUNK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_CHUNK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off during reset
`define SCCA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scca: same-cycle check failed");

// Next-cycle implication, off during reset
`define SCCA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scca: next-cycle check failed");

`endif

// ===== hw/rtl/scca_pkg.sv =====
// Package for the size class chunk allocator: field widths, opcodes,
// status codes and the token that travels down the cell chain. No dependencies.
`default_nettype none

package scca_pkg;

  // Defaults for the top level parameters
  localparam int unsigned CHUNK_COUNT_DEF   = 16;
  localparam int unsigned GRANULE_BYTES_DEF = 8;

  // Beat field widths
  localparam int unsigned OP_W          = 2;
  localparam int unsigned BYTES_W       = 10;
  localparam int unsigned OFFSET_W      = 11;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned USED_BYTES_W  = 11;
  localparam int unsigned USED_CHUNKS_W = 5;

  // Opcodes (opcode 3 behaves as a query)
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd2;

  // Work token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     alloc;    // allocate with nonzero size
    logic                     free;
    logic                     zero;     // zero-size allocate
    logic                     granted;
    logic [BYTES_W-1:0]       nbytes;
    logic [OFFSET_W-1:0]      foff;
    logic [OFFSET_W-1:0]      offset;   // granted chunk offset, 0 if none
    logic [USED_BYTES_W-1:0]  ubytes;   // running sum of in-use sizes
    logic [USED_CHUNKS_W-1:0] uchunks;  // running count of in-use chunks
  } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scca_ifs.sv =====
// Request and response channel interfaces of the chunk allocator.
// Depends on scca_pkg for field widths.
`default_nettype none

interface scca_req_if;
  logic                           valid;
  logic                           ready;
  logic [scca_pkg::OP_W-1:0]      opcode;
  logic [scca_pkg::BYTES_W-1:0]   request_bytes;
  logic [scca_pkg::OFFSET_W-1:0]  free_offset;

  modport source (output valid, output opcode, output request_bytes, output free_offset,
                  input ready);
  modport sink   (input valid, input opcode, input request_bytes, input free_offset,
                  output ready);
endinterface

interface scca_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [scca_pkg::STATUS_W-1:0]      status;
  logic [scca_pkg::OFFSET_W-1:0]      chunk_offset;
  logic [scca_pkg::USED_BYTES_W-1:0]  used_bytes;
  logic [scca_pkg::USED_CHUNKS_W-1:0] used_chunks;

  modport source (output valid, output status, output chunk_offset, output used_bytes,
                  output used_chunks, input ready);
  modport sink   (input valid, input status, input chunk_offset, input used_bytes,
                  input used_chunks, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/size_class_chunk_allocator.sv =====
// Size class chunk allocator: a chain of chunk cells plus the result register.
// Depends on scca_pkg, scca_ifs, scca_cell and the assertion macro header.
//
//   Channel  Dir  Handshake     Beat contents
//   req      in   valid/ready   opcode, request_bytes, free_offset
//   rsp      out  valid/ready   status, chunk_offset, used_bytes, used_chunks
//
// A request beat walks the chain one cell per cycle while the chain is not frozen,
// then lands in the result register. One beat is in the chain at a time; the next
// request is taken as soon as the result is registered, even while rsp waits.
// A stalled rsp freezes the chain once the beat reaches the last cell. Reset (rst,
// synchronous) frees every chunk.
`default_nettype none

`include "size_class_chunk_allocator_macros.svh"

module size_class_chunk_allocator #(
  parameter int unsigned CHUNK_COUNT   = scca_pkg::CHUNK_COUNT_DEF,
  parameter int unsigned GRANULE_BYTES = scca_pkg::GRANULE_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  scca_req_if.sink    req,
  scca_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic                   adv;
  logic                   load;
  scca_pkg::token_t       entry;
  scca_pkg::token_t       tok [CHUNK_COUNT];
  logic [CHUNK_COUNT-1:0] tok_valid;
  scca_pkg::token_t       last;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Decode the request beat into a fresh token
  always_comb begin
    entry         = '0;
    entry.valid   = accept;
    entry.zero    = (req.opcode == scca_pkg::OP_ALLOC) && (req.request_bytes == '0);
    entry.alloc   = (req.opcode == scca_pkg::OP_ALLOC) && (req.request_bytes != '0);
    entry.free    = (req.opcode == scca_pkg::OP_FREE);
    entry.nbytes  = req.request_bytes;
    entry.foff    = req.free_offset;
  end

  // Cell chain
  for (genvar i = 0; i < CHUNK_COUNT; i++) begin : g_cell
    scca_pkg::token_t cin;
    if (i == 0) begin : g_head
      assign cin = entry;
    end else begin : g_link
      assign cin = tok[i-1];
    end
    scca_cell #(
      .INDEX         (i),
      .GRANULE_BYTES (GRANULE_BYTES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (cin),
      .tok_out (tok[i])
    );
    assign tok_valid[i] = tok[i].valid;
  end

  assign last = tok[CHUNK_COUNT-1];
  assign load = last.valid && (!rsp.valid || rsp.ready);
  assign adv  = !(last.valid && rsp.valid && !rsp.ready);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (last.zero) begin
        rsp.status <= scca_pkg::STATUS_ZERO;
      end else if (last.alloc && !last.granted) begin
        rsp.status <= scca_pkg::STATUS_NOSPACE;
      end else begin
        rsp.status <= scca_pkg::STATUS_OK;
      end
      rsp.chunk_offset <= last.offset;
      rsp.used_bytes   <= last.ubytes;
      rsp.used_chunks  <= last.uchunks;
    end
  end

  // Busy tracking
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  `SCCA_ASSERT_IMP(a_single_token, 1'b1, $onehot0(tok_valid))
  `SCCA_ASSERT_IMP(a_idle_chain_empty, state == ST_IDLE, tok_valid == '0)
  `SCCA_ASSERT_NXT(a_accept_enters_chain, accept, tok_valid[0])
  `SCCA_ASSERT_IMP(a_no_grant_offset_zero, rsp.valid && (rsp.status == scca_pkg::STATUS_ZERO || rsp.status == scca_pkg::STATUS_NOSPACE), rsp.chunk_offset == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/scca_cell.sv =====
// One chunk of the pool: its in-use bit and the token register to the next cell.
// Depends on scca_pkg.
`default_nettype none

module scca_cell #(
  parameter int unsigned INDEX         = 0,
  parameter int unsigned GRANULE_BYTES = scca_pkg::GRANULE_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire scca_pkg::token_t  tok_in,
  output scca_pkg::token_t       tok_out
);

  localparam int unsigned SIZE  = GRANULE_BYTES * (INDEX + 1);
  localparam int unsigned START = GRANULE_BYTES * INDEX * (INDEX + 1) / 2;
  // A start beyond the offset field can never match a free request
  localparam bit          START_REACHABLE = (START < (2 ** scca_pkg::OFFSET_W));
  localparam logic [scca_pkg::OFFSET_W-1:0]     START_LOW = START[scca_pkg::OFFSET_W-1:0];
  localparam logic [scca_pkg::USED_BYTES_W-1:0] SIZE_LOW  = SIZE[scca_pkg::USED_BYTES_W-1:0];

  logic             in_use;
  logic             in_use_next;
  logic             fits;
  logic             hit_alloc;
  logic             hit_free;
  scca_pkg::token_t tok_next;

  // Grant or release this chunk, then add it to the running usage
  always_comb begin
    fits        = (32'(tok_in.nbytes) <= SIZE);
    hit_alloc   = tok_in.valid && tok_in.alloc && !tok_in.granted && !in_use && fits;
    hit_free    = tok_in.valid && tok_in.free && START_REACHABLE &&
                  (tok_in.foff == START_LOW);
    in_use_next = in_use;
    if (hit_alloc) begin
      in_use_next = 1'b1;
    end else if (hit_free) begin
      in_use_next = 1'b0;
    end
    tok_next = tok_in;
    if (hit_alloc) begin
      tok_next.granted = 1'b1;
      tok_next.offset  = START_LOW;
    end
    if (in_use_next) begin
      tok_next.ubytes  = tok_in.ubytes + SIZE_LOW;
      tok_next.uchunks = tok_in.uchunks + scca_pkg::USED_CHUNKS_W'(1);
    end
  end

  // State bit and hand-off register; both hold while the chain is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use  <= 1'b0;
      tok_out <= '0;
    end else if (adv) begin
      in_use  <= in_use_next;
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_size_class_chunk_allocator.sv =====
// Self-checking testbench for size_class_chunk_allocator: random and directed
// allocate/free/query beats, checked against a bit-true pool predictor.
// Depends on scca_pkg, scca_ifs and the allocator RTL.
`timescale 1ns / 100ps

module tb_size_class_chunk_allocator;
  import scca_pkg::*;

  localparam int CHUNKS  = CHUNK_COUNT_DEF;
  localparam int GRANULE = GRANULE_BYTES_DEF;
  localparam int DRAIN_CYCLES = CHUNK_COUNT_DEF + 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_GAP = 24;

  // Spare opcode, decoded by the block as a query
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // One response beat
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [OFFSET_W-1:0]      chunk_offset;
    logic [USED_BYTES_W-1:0]  used_bytes;
    logic [USED_CHUNKS_W-1:0] used_chunks;
  } grant_t;

  // Pool predictor plus in-order compare of response beats
  class chunk_pool_scoreboard;
    bit [CHUNKS-1:0] chunk_busy;
    grant_t expected_grants[$];
    int mismatches;
    int requests, grants, no_space, zero_size, frees, queries, pool_full;

    function int chunk_base(int idx);
      return GRANULE * idx * (idx + 1) / 2;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTES_W-1:0] nbytes,
                               logic [OFFSET_W-1:0] foff);
      grant_t g;
      int cls;
      int idx;
      int sum_bytes;
      int sum_chunks;
      g.status = STATUS_OK;
      g.chunk_offset = '0;
      sum_bytes = 0;
      sum_chunks = 0;
      requests++;
      case (op)
        OP_ALLOC: begin
          if (nbytes == 0) begin
            g.status = STATUS_ZERO;
            zero_size++;
          end else begin
            // lowest free chunk at or above the size class
            cls = (int'(nbytes) - 1) / GRANULE;
            g.status = STATUS_NOSPACE;
            for (idx = cls; idx < CHUNKS; idx++) begin
              if (!chunk_busy[idx]) begin
                chunk_busy[idx] = 1'b1;
                g.chunk_offset = OFFSET_W'(chunk_base(idx));
                g.status = STATUS_OK;
                break;
              end
            end
            if (g.status == STATUS_OK) grants++;
            else no_space++;
          end
        end
        OP_FREE: begin
          // unmatched offsets leave the pool alone
          for (idx = 0; idx < CHUNKS; idx++) begin
            if (chunk_base(idx) == int'(foff)) chunk_busy[idx] = 1'b0;
          end
          frees++;
        end
        default: queries++;
      endcase
      for (idx = 0; idx < CHUNKS; idx++) begin
        if (chunk_busy[idx]) begin
          sum_bytes += GRANULE * (idx + 1);
          sum_chunks++;
        end
      end
      if (sum_chunks == CHUNKS) pool_full++;
      g.used_bytes = USED_BYTES_W'(sum_bytes);
      g.used_chunks = USED_CHUNKS_W'(sum_chunks);
      expected_grants.push_back(g);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.chunk_offset !== want.chunk_offset) begin
        $error("chunk_offset: expected %0d, got %0d", want.chunk_offset, got.chunk_offset);
        mismatches++;
      end
      if (got.used_bytes !== want.used_bytes) begin
        $error("used_bytes: expected %0d, got %0d", want.used_bytes, got.used_bytes);
        mismatches++;
      end
      if (got.used_chunks !== want.used_chunks) begin
        $error("used_chunks: expected %0d, got %0d", want.used_chunks, got.used_chunks);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   rsp_hold = 1'b0;
  int   req_idle_pct;
  int   rsp_stall_pct;
  chunk_pool_scoreboard sb;

  scca_req_if req_bus ();
  scca_rsp_if rsp_bus ();

  size_class_chunk_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Response sink: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Beat monitor on both channels
  always @(posedge clk) begin
    grant_t beat;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        beat.status = rsp_bus.status;
        beat.chunk_offset = rsp_bus.chunk_offset;
        beat.used_bytes = rsp_bus.used_bytes;
        beat.used_chunks = rsp_bus.used_chunks;
        sb.check_grant(beat);
      end
      if (req_bus.valid && req_bus.ready) begin
        sb.note_request(req_bus.opcode, req_bus.request_bytes, req_bus.free_offset);
      end
    end
  end

  // Offer one request beat, after an optional gap, and wait for acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input int nbytes, input int foff);
    int gap;
    if ($urandom_range(99) < req_idle_pct) begin
      gap = $urandom_range(MAX_GAP, 1);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.opcode <= op;
    req_bus.request_bytes <= BYTES_W'(nbytes);
    req_bus.free_offset <= OFFSET_W'(foff);
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  // Sink stops taking results for a long stretch
  task automatic hold_off_rsp(input int cycles);
    repeat (40) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rsp_hold <= 1'b0;
  endtask

  // Random traffic: alternating fill-heavy and drain-heavy stretches
  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int k;
    int roll;
    int alloc_pct;
    int nbytes;
    int foff;
    req_idle_pct = idle_pct;
    rsp_stall_pct <= stall_pct;
    for (k = 0; k < count; k++) begin
      alloc_pct = ((k / 40) % 2 == 0) ? 70 : 25;
      nbytes = $urandom_range(1023, 0);
      foff = $urandom_range(1087, 0);
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        roll = $urandom_range(99);
        if (roll < 3) nbytes = 0;
        else if (roll < 12) nbytes = $urandom_range(1023, 129);
        else if (roll < 50) nbytes = $urandom_range(32, 1);
        else nbytes = $urandom_range(128, 1);
        send_request(OP_ALLOC, nbytes, foff);
      end else if (roll < 92) begin
        // mostly real chunk starts, some stray offsets
        if ($urandom_range(99) < 85) foff = sb.chunk_base($urandom_range(CHUNKS - 1, 0));
        send_request(OP_FREE, nbytes, foff);
      end else begin
        send_request(($urandom_range(1) != 0) ? OP_QUERY : OP_SPARE, nbytes, foff);
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.opcode <= OP_QUERY;
    req_bus.request_bytes <= '0;
    req_bus.free_offset <= '0;
    req_idle_pct = 0;
    rsp_stall_pct <= 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_request(OP_QUERY, 1023, 1087);
    send_request(OP_SPARE, 0, 0);
    send_request(OP_ALLOC, 0, 1087);     // zero size
    send_request(OP_ALLOC, 1023, 0);     // oversized
    send_request(OP_ALLOC, 129, 0);      // just over the largest class
    send_request(OP_ALLOC, 128, 0);      // largest chunk
    send_request(OP_ALLOC, 121, 0);      // top class taken, nothing above
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 8, 0);        // class 0 taken, moves up
    send_request(OP_ALLOC, 9, 0);
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_FREE, 0, 1087);      // stray offset
    send_request(OP_FREE, 0, 7);
    send_request(OP_FREE, 1023, 0);
    send_request(OP_FREE, 0, 0);         // already free
    send_request(OP_FREE, 0, 480);
    send_request(OP_ALLOC, 120, 0);
    send_request(OP_ALLOC, 128, 0);
    send_request(OP_QUERY, 0, 0);

    // random phases; the long sink hold-off rides on the first one
    fork
      run_phase(0, 0, 333);
      hold_off_rsp(HOLD_OFF_CYCLES);
    join
    run_phase(72, 0, 333);
    run_phase(0, 72, 333);
    run_phase(9, 9, 333);
    req_bus.valid <= 1'b0;

    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d grants, %0d no-space, %0d zero-size, %0d frees, %0d queries",
             sb.requests, sb.grants, sb.no_space, sb.zero_size, sb.frees, sb.queries);
    $display("Pool was completely full after %0d requests", sb.pool_full);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== size_class_chunk_allocator.f =====
+incdir+hw/rtl
hw/rtl/scca_pkg.sv
hw/rtl/scca_ifs.sv
hw/rtl/scca_cell.sv
hw/rtl/size_class_chunk_allocator.sv
tb/tb_size_class_chunk_allocator.sv
